// ===== rtl/fwct_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the frame window cache tag store.
// No dependencies; used by frame_window_cache_tags.
package fwct_pkg;

  localparam int SLOTS  = 32;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam int FRAME_IN_W = 32;
  localparam int FRAME_W    = 31;
  localparam int RADIUS_W   = 4;
  localparam int SLOT_OUT_W = 5;
  localparam int MASK_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME = 2'd2;

endpackage

// ===== rtl/frame_window_cache_tags.sv =====
`timescale 1ns / 1ps
// Tag store for a window cache of video frames: clamp, slot scan, store.
// Depends on fwct_pkg.
//
//  channel  | signals                                        | flow control
//  ---------+------------------------------------------------+-------------------------
//  request  | start, busy, frame_req                         | taken on start & !busy
//  result   | done, served_frame, hit, slot, stored,         | one-cycle strobe on done,
//           | overflow, release_mask                         | no back-pressure
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | taken on valid & ready
//
// A cached request goes through a setup state, a scan of n = min(2*radius + 1, SLOTS)
// active slots, one at a time, through the shared window compare, and a finish state.
// A bypass request skips the scan. done strobes in the first cycle with busy low.
// Synchronous reset clears state, done, config and slot flags; the table starts empty.
// The receiver cannot stall; configuration is taken only while busy is low.
module frame_window_cache_tags (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [fwct_pkg::FRAME_IN_W-1:0] frame_req,
  output logic                                 done,
  output logic        [fwct_pkg::FRAME_W-1:0]    served_frame,
  output logic                                 hit,
  output logic        [fwct_pkg::SLOT_OUT_W-1:0] slot,
  output logic                                 stored,
  output logic                                 overflow,
  output logic        [fwct_pkg::MASK_W-1:0]     release_mask,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [fwct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [fwct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fwct_pkg::*;

  typedef enum logic [1:0] {IDLE, SETUP, SCAN, FINISH} state_t;

  state_t state;

  logic                mode;
  logic [RADIUS_W-1:0] radius;
  logic [FRAME_W-1:0]  last_frame;

  logic [FRAME_W-1:0] slot_frame [SLOTS];
  logic [SLOTS-1:0]   slot_used;
  logic [SLOTS-1:0]   slot_deletable;
  logic [SLOTS-1:0]   slot_released;

  logic [FRAME_W-1:0]  req;
  logic signed [32:0]  win_hi;
  logic signed [32:0]  win_lo;
  logic [SLOT_W-1:0]   k;
  logic [SLOT_W-1:0]   last_idx;
  logic                hit_f;
  logic [SLOT_W-1:0]   hit_idx;
  logic                found;
  logic [SLOT_W-1:0]   free_idx;
  logic [MASK_W-1:0]   mask;

  logic [FRAME_W-1:0]  req_next;
  logic [FRAME_W-1:0]  cur_frame;
  logic signed [32:0]  cur_ext;
  logic                cur_used;
  logic                cur_far;
  logic                cur_cand;
  logic                cfg_we;

  assign busy      = (state != IDLE);
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Clamp the request to 0..last_frame.
  always_comb begin
    if (frame_req[FRAME_IN_W-1]) begin
      req_next = '0;
    end else if (frame_req[FRAME_W-1:0] > last_frame) begin
      req_next = last_frame;
    end else begin
      req_next = frame_req[FRAME_W-1:0];
    end
  end

  // Shared window compare on the slot under the scan pointer.
  assign cur_frame = slot_frame[k];
  assign cur_used  = slot_used[k];
  assign cur_ext   = signed'({2'b00, cur_frame});
  assign cur_far   = (cur_ext > win_hi) || (cur_ext < win_lo);
  assign cur_cand  = !cur_used || slot_deletable[k] || cur_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      done           <= 1'b0;
      mode           <= 1'b0;
      radius         <= '0;
      last_frame     <= '0;
      slot_used      <= '0;
      slot_deletable <= '0;
      slot_released  <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:       mode <= cfg_data[0];
          REG_RADIUS: begin
            radius         <= cfg_data[RADIUS_W-1:0];
            slot_used      <= '0;
            slot_deletable <= '0;
            slot_released  <= '0;
          end
          REG_LAST_FRAME: last_frame <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        IDLE: begin
          if (start) begin
            req   <= req_next;
            hit_f <= 1'b0;
            found <= 1'b0;
            mask  <= '0;
            k     <= '0;
            state <= SETUP;
          end
        end
        SETUP: begin
          win_hi <= signed'({2'b00, req}) + signed'(33'(radius));
          win_lo <= signed'({2'b00, req}) - signed'(33'(radius));
          if (32'(radius) * 2 > SLOTS - 1) begin
            last_idx <= SLOT_W'(SLOTS - 1);
          end else begin
            last_idx <= SLOT_W'(32'(radius) * 2);
          end
          state <= mode ? SCAN : FINISH;
        end
        SCAN: begin
          if (cur_used) begin
            if (cur_frame == req) begin
              hit_f   <= 1'b1;
              hit_idx <= k;
            end
            if (cur_far) begin
              slot_deletable[k] <= 1'b1;
              if (!slot_released[k]) begin
                slot_released[k] <= 1'b1;
                // the mask is as wide as the slot count, so every slot has a bit
                mask <= mask | (MASK_W'(1) << k);
              end
            end
          end
          if (cur_cand && !found) begin
            found    <= 1'b1;
            free_idx <= k;
          end
          if (k == last_idx) begin
            state <= FINISH;
          end else begin
            k <= k + 1'b1;
          end
        end
        FINISH: begin
          done         <= 1'b1;
          served_frame <= req;
          hit          <= mode && hit_f;
          stored       <= mode && !hit_f && found;
          overflow     <= mode && !hit_f && !found;
          release_mask <= mode ? mask : '0;
          if (mode && hit_f) begin
            slot <= SLOT_OUT_W'(hit_idx);
          end else if (mode && found) begin
            slot                     <= SLOT_OUT_W'(free_idx);
            slot_frame[free_idx]     <= req;
            slot_used[free_idx]      <= 1'b1;
            slot_deletable[free_idx] <= 1'b0;
            slot_released[free_idx]  <= 1'b0;
          end else begin
            slot <= '0;
          end
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_hit_not_stored: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && stored))
    else $error("hit and stored in one result");

  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (!hit && !stored && slot == '0))
    else $error("overflow result carries a slot");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_radius_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_RADIUS) |=>
      (slot_used == '0 && slot_released == '0))
    else $error("radius write did not clear the table");

endmodule
